// ===== hw/rtl/ile_pkg.sv =====
`default_nettype none
package ile_pkg;
  localparam int DEPTH_DEFAULT = 256;
  localparam int WORD_BITS_DEFAULT = 32;
  localparam int REQ_BITS = 4;
  localparam int POS_BITS = 9;
  localparam int POS2_BITS = 8;
  localparam int IN_WORD_BITS = 32;
  localparam int STATUS_BITS = 3;
  localparam int COUNT_BITS = 9;
  localparam int CFG_BITS = 9;
  localparam logic [CFG_BITS-1:0] MAX_ENTRIES_RESET = 9'd256;

  typedef enum logic [3:0] {
    REQ_INSERT = 4'd0, REQ_REMOVE = 4'd1, REQ_READ = 4'd2, REQ_WRITE = 4'd3,
    REQ_FIND = 4'd4, REQ_COUNT = 4'd5, REQ_RM_FIRST = 4'd6, REQ_RM_LAST = 4'd7,
    REQ_RM_ALL = 4'd8, REQ_SWAP_IDX = 4'd9, REQ_SWAP_VAL = 4'd10,
    REQ_REPLACE = 4'd11, REQ_REVERSE = 4'd12, REQ_CLEAR = 4'd13,
    REQ_RSV14 = 4'd14, REQ_RSV15 = 4'd15
  } req_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_EMPTY = 3'd1, ST_BAD_INDEX = 3'd2, ST_NOT_FOUND = 3'd3,
    ST_FULL = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_UP_RD, S_UP_WR, S_DN_RD, S_DN_WR,
    S_SWAP_RD_A, S_SWAP_RD_B, S_SWAP_WR_A, S_SWAP_WR_B, S_DONE
  } fsm_t;
endpackage
`default_nettype wire

// ===== hw/rtl/ile_mem.sv =====
`default_nettype none
module ile_mem #(
  parameter int DEPTH = 256,
  parameter int WORD_BITS = 32,
  parameter int AW = $clog2(DEPTH)
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [AW-1:0]        waddr,
  input  wire logic [WORD_BITS-1:0] wdata,
  input  wire logic [AW-1:0]        raddr,
  output logic      [WORD_BITS-1:0] rdata
);
  logic [WORD_BITS-1:0] store [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      store[waddr] <= wdata;
    end
    rdata <= store[raddr];
  end
endmodule
`default_nettype wire

// ===== hw/rtl/indexed_list_engine_unit.sv =====
`default_nettype none
// Bounded ordered list of words held in one memory with a read port and a write port.
// One request is processed at a time, and the next is taken only after the result of the
// previous one has been transferred. A request that only checks its fields, writes one entry
// or clears the list goes from its transfer straight to the done state; a read or a removal
// first passes through the memory read and check states. Searches and shifts walk the
// entries one at a time and reversal swaps one pair at a time, so the slowest request is
// removing the last match when it sits at index 0. No two accesses to the same entry ever
// overlap, so the memory needs no forwarding.
module indexed_list_engine_unit
  import ile_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT,
  parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CFG_BITS-1:0]      cfg_data,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [REQ_BITS-1:0]      req_type,
  input  wire logic [POS_BITS-1:0]      position,
  input  wire logic [POS2_BITS-1:0]     other_position,
  input  wire logic [IN_WORD_BITS-1:0]  word_value,
  input  wire logic [IN_WORD_BITS-1:0]  other_value,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [STATUS_BITS-1:0]        status,
  output logic [IN_WORD_BITS-1:0]       read_word,
  output logic [POS2_BITS-1:0]          found_index,
  output logic [COUNT_BITS-1:0]         match_count,
  output logic [COUNT_BITS-1:0]         entry_total
);
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > POS_BITS) ? CW : POS_BITS;

  fsm_t state, state_next;
  fsm_t accept_state, scan_state;
  status_t accept_status, scan_status, r_status;
  logic [CFG_BITS-1:0] max_entries;
  logic [CW-1:0] count;
  req_t op, req_code;
  logic [CW-1:0] pos;
  logic [WORD_BITS-1:0] wv, ov, held, r_word;
  logic [CW-1:0] i, j, a_idx, b_idx, cnt, r_fidx;
  logic hit_a, hit_b;

  logic mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [WORD_BITS-1:0] mem_wdata, mem_rdata;

  ile_mem #(.DEPTH(DEPTH), .WORD_BITS(WORD_BITS)) u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  logic [XW-1:0] pos_x, pos2_x, count_x, limit;
  assign req_code = req_t'(req_type);
  assign pos_x = XW'(position);
  assign pos2_x = XW'(other_position);
  assign count_x = XW'(count);
  assign limit = (XW'(max_entries) > XW'(DEPTH)) ? XW'(DEPTH) : XW'(max_entries);

  assign in_ready = (state == S_IDLE) && !out_valid;
  assign cfg_ready = 1'b1;
  logic accept;
  assign accept = in_valid && in_ready;

  logic [CW-1:0] i_inc, j_inc, kept, a_inc, b_dec;
  logic match, alt_match, last;
  assign i_inc = i + CW'(1);
  assign j_inc = j + CW'(1);
  assign a_inc = a_idx + CW'(1);
  assign b_dec = b_idx - CW'(1);
  assign match = (mem_rdata == wv);
  assign alt_match = (mem_rdata == ov);
  assign last = (i_inc >= count);
  // Number of entries kept so far, counting the one being checked.
  assign kept = match ? j : j_inc;

  always_comb begin
    accept_status = ST_OK;
    accept_state = S_DONE;
    unique case (req_code)
      REQ_INSERT: begin
        if (pos_x > count_x) accept_status = ST_BAD_INDEX;
        else if (count_x >= limit) accept_status = ST_FULL;
        else accept_state = S_UP_RD;
      end
      REQ_CLEAR, REQ_RSV14, REQ_RSV15: accept_state = S_DONE;
      default: begin
        if (count == '0) begin
          accept_status = ST_EMPTY;
        end else begin
          unique case (req_code)
            REQ_REMOVE, REQ_READ, REQ_WRITE: begin
              if (pos_x >= count_x) accept_status = ST_BAD_INDEX;
              else if (req_code != REQ_WRITE) accept_state = S_SCAN_RD;
            end
            REQ_SWAP_IDX: begin
              if (pos_x >= count_x || pos2_x >= count_x) accept_status = ST_BAD_INDEX;
              else accept_state = S_SWAP_RD_A;
            end
            REQ_REVERSE: if (count > CW'(1)) accept_state = S_SWAP_RD_A;
            default: accept_state = S_SCAN_RD;
          endcase
        end
      end
    endcase
  end

  always_comb begin
    scan_state = S_SCAN_RD;
    scan_status = ST_OK;
    unique case (op)
      REQ_READ: scan_state = S_DONE;
      REQ_REMOVE: scan_state = S_DN_RD;
      REQ_FIND, REQ_REPLACE, REQ_RM_FIRST: begin
        if (match) begin
          scan_state = (op == REQ_RM_FIRST) ? S_DN_RD : S_DONE;
        end else if (last) begin
          scan_state = S_DONE; scan_status = ST_NOT_FOUND;
        end
      end
      REQ_RM_LAST: begin
        if (last) begin
          if (hit_a || match) scan_state = S_DN_RD;
          else begin scan_state = S_DONE; scan_status = ST_NOT_FOUND; end
        end
      end
      REQ_SWAP_VAL: begin
        if ((hit_a || match) && (hit_b || alt_match)) begin
          scan_state = S_SWAP_RD_A;
        end else if (last) begin
          scan_state = S_DONE; scan_status = ST_NOT_FOUND;
        end
      end
      default: if (last) scan_state = S_DONE;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = accept_state;
      S_SCAN_RD: state_next = S_SCAN_CHK;
      S_SCAN_CHK: state_next = scan_state;
      S_UP_RD: state_next = (i == pos) ? S_DONE : S_UP_WR;
      S_UP_WR: state_next = S_UP_RD;
      S_DN_RD: state_next = (j_inc >= count) ? S_DONE : S_DN_WR;
      S_DN_WR: state_next = S_DN_RD;
      S_SWAP_RD_A: state_next = S_SWAP_RD_B;
      S_SWAP_RD_B: state_next = S_SWAP_WR_A;
      S_SWAP_WR_A: state_next = S_SWAP_WR_B;
      S_SWAP_WR_B: begin
        state_next = (op == REQ_REVERSE && a_inc < b_dec) ? S_SWAP_RD_A : S_DONE;
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    mem_we = 1'b0;
    mem_waddr = '0;
    mem_wdata = mem_rdata;
    mem_raddr = '0;
    unique case (state)
      S_IDLE: begin
        if (accept && req_code == REQ_WRITE && accept_status == ST_OK) begin
          mem_we = 1'b1; mem_waddr = AW'(position); mem_wdata = WORD_BITS'(word_value);
        end
      end
      S_SCAN_RD: mem_raddr = AW'(i);
      S_SCAN_CHK: begin
        if (op == REQ_REPLACE && match) begin
          mem_we = 1'b1; mem_waddr = AW'(i); mem_wdata = ov;
        end else if (op == REQ_RM_ALL && !match) begin
          mem_we = 1'b1; mem_waddr = AW'(j);
        end
      end
      S_UP_RD: begin
        if (i == pos) begin
          mem_we = 1'b1; mem_waddr = AW'(pos); mem_wdata = wv;
        end else begin
          mem_raddr = AW'(i - CW'(1));
        end
      end
      S_UP_WR: begin mem_we = 1'b1; mem_waddr = AW'(i); end
      S_DN_RD: mem_raddr = AW'(j_inc);
      S_DN_WR: begin mem_we = 1'b1; mem_waddr = AW'(j); end
      S_SWAP_RD_A: mem_raddr = AW'(a_idx);
      S_SWAP_RD_B: mem_raddr = AW'(b_idx);
      S_SWAP_WR_A: begin mem_we = 1'b1; mem_waddr = AW'(a_idx); end
      S_SWAP_WR_B: begin mem_we = 1'b1; mem_waddr = AW'(b_idx); mem_wdata = held; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      max_entries <= MAX_ENTRIES_RESET;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) max_entries <= cfg_data;
      if (state == S_DONE) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op <= req_code;
            pos <= CW'(position);
            wv <= WORD_BITS'(word_value);
            ov <= WORD_BITS'(other_value);
            r_status <= accept_status;
            r_word <= '0;
            r_fidx <= '0;
            cnt <= '0;
            hit_a <= 1'b0;
            hit_b <= 1'b0;
            j <= '0;
            if (req_code == REQ_INSERT) i <= count;
            else if (req_code == REQ_REMOVE || req_code == REQ_READ) i <= CW'(position);
            else i <= '0;
            if (req_code == REQ_SWAP_IDX) begin
              a_idx <= CW'(position); b_idx <= CW'(other_position);
            end else begin
              a_idx <= '0; b_idx <= count - CW'(1);
            end
            if (req_code == REQ_CLEAR) count <= '0;
          end
        end
        S_SCAN_CHK: begin
          r_status <= scan_status;
          if (scan_state == S_SCAN_RD) i <= i_inc;
          unique case (op)
            REQ_READ, REQ_REMOVE: begin r_word <= mem_rdata; j <= i; end
            REQ_FIND: if (match) r_fidx <= i;
            REQ_RM_FIRST: if (match) begin r_word <= mem_rdata; j <= i; end
            REQ_COUNT: if (match) cnt <= cnt + CW'(1);
            REQ_RM_LAST: begin
              if (match) begin a_idx <= i; hit_a <= 1'b1; r_word <= mem_rdata; end
              if (last) j <= match ? i : a_idx;
            end
            REQ_SWAP_VAL: begin
              if (match && !hit_a) begin a_idx <= i; hit_a <= 1'b1; end
              if (alt_match && !hit_b) begin b_idx <= i; hit_b <= 1'b1; end
            end
            REQ_RM_ALL: begin
              j <= kept;
              if (last) begin count <= kept; cnt <= count - kept; end
            end
            default: ;
          endcase
        end
        S_UP_RD: if (i == pos) count <= count + CW'(1);
        S_UP_WR: i <= i - CW'(1);
        S_DN_RD: if (j_inc >= count) count <= count - CW'(1);
        S_DN_WR: j <= j_inc;
        S_SWAP_RD_B: held <= mem_rdata;
        S_SWAP_WR_B: begin
          if (state_next == S_SWAP_RD_A) begin a_idx <= a_inc; b_idx <= b_dec; end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE) begin
      status <= r_status;
      read_word <= IN_WORD_BITS'(r_word);
      found_index <= POS2_BITS'(r_fidx);
      match_count <= COUNT_BITS'(cnt);
      entry_total <= COUNT_BITS'(count);
    end
  end
endmodule
`default_nettype wire
